// ----- rtl/core/ilp_pkg.sv -----
// Shared types, character codes and helper functions of the integer literal parser.
package ilp_pkg;

   // Width of the accumulated magnitude.
   localparam int MagBits = 64;
   // Headroom above the magnitude for one digit step (times sixteen plus a digit).
   localparam int StepBits = MagBits + 4;

   localparam logic [7:0] ChPlus  = 8'h2B;
   localparam logic [7:0] ChMinus = 8'h2D;
   localparam logic [7:0] ChZero  = 8'h30;
   localparam logic [7:0] ChLowX  = 8'h78;
   localparam logic [7:0] ChUpX   = 8'h58;
   localparam logic [7:0] ChLowU  = 8'h75;
   localparam logic [7:0] ChUpU   = 8'h55;
   localparam logic [7:0] ChLowL  = 8'h6C;
   localparam logic [7:0] ChUpL   = 8'h4C;

   typedef enum logic [5:0] {
      PhStart  = 6'b000001,
      PhSigned = 6'b000010,
      PhZpend  = 6'b000100,
      PhDigits = 6'b001000,
      PhSuffix = 6'b010000,
      PhError  = 6'b100000
   } phase_type;

   typedef enum logic [1:0] {
      RadDec = 2'd0,
      RadHex = 2'd1,
      RadOct = 2'd2
   } radix_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       has_char;
      logic       last;
   } item_type;

   typedef struct packed {
      logic               accepted;
      logic [MagBits-1:0] magnitude;
      logic               negative;
      logic               fits;
   } result_type;

   // Digit value of a hex character; bit 4 flags a valid hex digit.
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] v;
      v = 5'd0;
      case (c) inside
         [8'h30:8'h39]: v = {1'b1, 4'(c - 8'h30)};
         [8'h61:8'h66]: v = {1'b1, 4'(c - 8'h57)};
         [8'h41:8'h46]: v = {1'b1, 4'(c - 8'h37)};
         default:       v = 5'd0;
      endcase
      return v;
   endfunction

   function automatic logic is_suffix(input logic [7:0] c);
      return (c == ChLowU) || (c == ChUpU) || (c == ChLowL) || (c == ChUpL);
   endfunction

endpackage

// ----- rtl/core/ilp_accum.sv -----
// One digit step of the magnitude: digit check, shift-and-add by the radix, fit check.
module ilp_accum (
   input  logic [7:0]                  ch,
   input  ilp_pkg::radix_type          radix,
   input  logic [ilp_pkg::MagBits-1:0] acc,
   output logic                        is_digit,
   output logic [ilp_pkg::MagBits-1:0] acc_next,
   output logic                        step_fits
);
   import ilp_pkg::*;

   logic [4:0]          hv;
   logic [StepBits-1:0] acc_wide;
   logic [StepBits-1:0] scaled;
   logic [StepBits-1:0] total;

   assign hv       = hex_value(ch);
   assign acc_wide = StepBits'(acc);

   always_comb begin
      case (radix)
         RadHex: begin
            is_digit = hv[4];
            scaled   = acc_wide << 4;
         end
         RadOct: begin
            is_digit = hv[4] && (hv[3:0] < 4'd8);
            scaled   = acc_wide << 3;
         end
         default: begin
            is_digit = hv[4] && (hv[3:0] < 4'd10);
            scaled   = (acc_wide << 3) + (acc_wide << 1);
         end
      endcase
   end

   // The true value fits exactly when nothing spills above the magnitude width.
   assign total     = scaled + StepBits'(hv[3:0]);
   assign acc_next  = total[MagBits-1:0];
   assign step_fits = (total[StepBits-1:MagBits] == '0);

endmodule

// ----- rtl/core/ilp_parse.sv -----
// Parser state of one literal and the update that each character applies to it.
module ilp_parse (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  ilp_pkg::item_type   item,
   output ilp_pkg::result_type result
);
   import ilp_pkg::*;

   phase_type          phase_ff, phase_in;
   radix_type          radix_ff, radix_in;
   logic [MagBits-1:0] accum_ff, accum_in;
   logic               minus_ff, minus_in;
   logic               no_ovf_ff, no_ovf_in;
   logic               dseen_ff, dseen_in;

   radix_type          digit_radix;
   logic               is_digit;
   logic [MagBits-1:0] acc_step;
   logic               step_fits;
   logic               suffix_ch;

   // Behind a pending zero the digit is read as octal.
   assign digit_radix = (phase_ff == PhZpend) ? RadOct : radix_ff;
   assign suffix_ch   = is_suffix(item.ch);

   ilp_accum u_accum (
      .ch        (item.ch),
      .radix     (digit_radix),
      .acc       (accum_ff),
      .is_digit  (is_digit),
      .acc_next  (acc_step),
      .step_fits (step_fits)
   );

   always_comb begin
      logic take_digit;
      take_digit = 1'b0;
      phase_in   = phase_ff;
      radix_in   = radix_ff;
      accum_in   = accum_ff;
      minus_in   = minus_ff;
      no_ovf_in  = no_ovf_ff;
      dseen_in   = dseen_ff;

      if (item.has_char) begin
         case (phase_ff)
            PhStart, PhSigned: begin
               if ((phase_ff == PhStart) && ((item.ch == ChPlus) || (item.ch == ChMinus))) begin
                  minus_in = (item.ch == ChMinus);
                  phase_in = PhSigned;
               end else if ((item.ch == ChZero) && !item.last) begin
                  phase_in = PhZpend;
                  dseen_in = 1'b1;
               end else begin
                  phase_in   = PhDigits;
                  radix_in   = RadDec;
                  take_digit = 1'b1;
               end
            end
            PhZpend: begin
               phase_in = PhDigits;
               if ((item.ch == ChLowX) || (item.ch == ChUpX)) begin
                  radix_in = RadHex;
                  dseen_in = 1'b0;
               end else begin
                  radix_in   = RadOct;
                  take_digit = 1'b1;
               end
            end
            PhDigits: take_digit = 1'b1;
            PhSuffix: begin
               if (!suffix_ch) begin
                  phase_in = PhError;
               end
            end
            default: phase_in = PhError;
         endcase

         if (take_digit) begin
            if (is_digit) begin
               no_ovf_in = no_ovf_ff && step_fits;
               accum_in  = acc_step;
               dseen_in  = 1'b1;
            end else if (suffix_ch) begin
               phase_in = PhSuffix;
            end else begin
               phase_in = PhError;
            end
         end
      end
   end

   assign result.accepted  = dseen_in &&
                             ((phase_in == PhDigits) || (phase_in == PhSuffix) ||
                              (phase_in == PhZpend));
   assign result.magnitude = accum_in;
   assign result.negative  = minus_in;
   assign result.fits      = no_ovf_in;

   always_ff @(posedge clock) begin
      if (reset || (step_en && item.last)) begin
         phase_ff  <= PhStart;
         radix_ff  <= RadDec;
         accum_ff  <= '0;
         minus_ff  <= 1'b0;
         no_ovf_ff <= 1'b1;
         dseen_ff  <= 1'b0;
      end else if (step_en) begin
         phase_ff  <= phase_in;
         radix_ff  <= radix_in;
         accum_ff  <= accum_in;
         minus_ff  <= minus_in;
         no_ovf_ff <= no_ovf_in;
         dseen_ff  <= dseen_in;
      end
   end

`ifndef SYNTHESIS
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      step_en && item.last |=> (phase_ff == PhStart) && no_ovf_ff && !dseen_ff &&
                               (accum_ff == '0))
      else $error("parser state not cleared after the last item");

   a_overflow_needs_digits: assert property (@(posedge clock) disable iff (reset)
      !no_ovf_ff |-> (phase_ff == PhDigits) || (phase_ff == PhSuffix) ||
                     (phase_ff == PhError))
      else $error("overflow flagged outside the digit phases");

   a_hex_after_prefix: assert property (@(posedge clock) disable iff (reset)
      (radix_ff == RadHex) |-> (phase_ff == PhDigits) || (phase_ff == PhSuffix) ||
                               (phase_ff == PhError))
      else $error("hex radix set before the prefix was complete");
`endif

endmodule

// ----- rtl/core/int_literal_parser.sv -----
// Top level of the streaming C integer literal parser.
//
// The block reads one candidate C integer literal, one character per item, and on the
// item marked with tlast returns one result item: whether the text is one complete
// integer literal (optional sign, then 0x/0X and hex digits, a leading zero and octal
// digits, or decimal digits, then only u/U/l/L suffix characters), the magnitude modulo
// 2^64, the sign, and whether the true value fit in 64 bits. After the result the
// parser is back in its reset state, ready for the next literal. An item with tuser
// low carries no character; on a last item it closes the literal at what was seen.
// Rate: one item per clock cycle, sustained, but for the stall below. An item sits in the
// input register while the parser applies it in a single pass (digit check, multiply by the
// radix as shifts and adds, fit check), and the result of a last item is captured in the
// output register; rsp_tvalid rises when the output register loads, and the result is
// held there until rsp_tready takes it. The only stall is a last item that finds
// an unread result in the output register while rsp_tready is low.
module int_literal_parser (
   input  logic        clock,
   input  logic        reset,
   // Input channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic        req_tuser,   // [0] has_char
   input  logic        req_tlast,   // last
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata    // [0] accepted, [64:1] magnitude, [65] negative,
                                    // [66] fits, [71:67] zero
);
   import ilp_pkg::*;

   item_type   in_ff;
   logic       in_valid_ff, in_valid_in;
   result_type out_ff;
   logic       out_valid_ff, out_valid_in;
   result_type result;
   logic       req_take;
   logic       advance;

   assign req_take = req_tvalid && req_tready;

   // The held item moves on unless it is a last item and the output slot is full and not being read.
   assign advance    = in_valid_ff && (!in_ff.last || !out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_comb begin
      if (advance && in_ff.last) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   ilp_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers load on their handshakes only; they need no reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ff.ch       <= req_tdata;
         in_ff.has_char <= req_tuser;
         in_ff.last     <= req_tlast;
      end
      if (advance && in_ff.last) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, out_ff.fits, out_ff.negative, 64'(out_ff.magnitude),
                        out_ff.accepted};

`ifndef SYNTHESIS
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      advance && in_ff.last |=> rsp_tvalid)
      else $error("last item did not produce a result");

   a_stalled_item_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_ff))
      else $error("stalled input item was lost or changed");

   a_full_blocks_last: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && in_ff.last && out_valid_ff && !rsp_tready |-> !req_tready && !advance)
      else $error("last item advanced over an unread result");
`endif

endmodule
